[design/esn_pkg.sv]
// ----------------------------------------------------------------------------
// esn_pkg
// shared types and character constants for the emergency command sniffer
// ----------------------------------------------------------------------------
package esn_pkg;

   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_2     = 8'h32;
   localparam logic [7:0] CHAR_4     = 8'h34;
   localparam logic [7:0] CHAR_8     = 8'h38;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_KILL    = 2'd2,
      ACT_QSTOP   = 2'd3
   } action_type;

   typedef enum logic [11:0] {
      ST_START = 12'b0000_0000_0001,
      ST_N     = 12'b0000_0000_0010,
      ST_M     = 12'b0000_0000_0100,
      ST_M1    = 12'b0000_0000_1000,
      ST_M10   = 12'b0000_0001_0000,
      ST_M11   = 12'b0000_0010_0000,
      ST_M4    = 12'b0000_0100_0000,
      ST_M41   = 12'b0000_1000_0000,
      ST_M108  = 12'b0001_0000_0000,
      ST_M112  = 12'b0010_0000_0000,
      ST_M410  = 12'b0100_0000_0000,
      ST_SKIP  = 12'b1000_0000_0000
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } stage_type;

endpackage

[design/esn_ifs.sv]
// ----------------------------------------------------------------------------
// esn_ifs
// valid/ready stream channels for received bytes and action results
// ----------------------------------------------------------------------------
interface esn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface esn_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       killed;

   modport source (output valid, output action, output killed, input ready);
   modport sink (input valid, input action, input killed, output ready);
endinterface

[design/esn_in_reg.sv]
// ----------------------------------------------------------------------------
// esn_in_reg
// input register stage, holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
module esn_in_reg import esn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   esn_req_if.sink   req,
   input  logic      take,
   output stage_type stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       accept;

   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

[design/esn_parser.sv]
// ----------------------------------------------------------------------------
// esn_parser
// line parser state machine, killed flag and result register
// ----------------------------------------------------------------------------
module esn_parser import esn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   input  logic      detect_enable,
   output logic      take,
   esn_rsp_if.source rsp
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic            killed_ff;
   logic            killed_in;
   logic            valid_ff;
   logic            valid_in;
   action_type      action_ff;
   action_type      action_in;
   logic            fire;
   logic [7:0]      c;
   logic            is_digit;

   assign take     = !valid_ff || rsp.ready;
   assign fire     = stage.valid && take;
   assign c        = stage.rx_byte;
   assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);

   always_comb begin
      state_in  = state_ff;
      killed_in = killed_ff;
      action_in = ACT_NONE;
      unique case (state_ff)
         ST_START: begin
            if (c == CHAR_SPACE) state_in = ST_START;
            else if (c == CHAR_N) state_in = ST_N;
            else if (c == CHAR_M) state_in = ST_M;
            else state_in = ST_SKIP;
         end
         ST_N: begin
            if (is_digit || c == CHAR_MINUS || c == CHAR_SPACE) state_in = ST_N;
            else if (c == CHAR_M) state_in = ST_M;
            else state_in = ST_SKIP;
         end
         ST_M: begin
            if (c == CHAR_SPACE) state_in = ST_M;
            else if (c == CHAR_1) state_in = ST_M1;
            else if (c == CHAR_4) state_in = ST_M4;
            else state_in = ST_SKIP;
         end
         ST_M1: begin
            if (c == CHAR_0) state_in = ST_M10;
            else if (c == CHAR_1) state_in = ST_M11;
            else state_in = ST_SKIP;
         end
         ST_M10: begin
            state_in = (c == CHAR_8) ? ST_M108 : ST_SKIP;
         end
         ST_M11: begin
            state_in = (c == CHAR_2) ? ST_M112 : ST_SKIP;
         end
         ST_M4: begin
            state_in = (c == CHAR_1) ? ST_M41 : ST_SKIP;
         end
         ST_M41: begin
            state_in = (c == CHAR_0) ? ST_M410 : ST_SKIP;
         end
         ST_M108: begin
            if (c == CHAR_LF) begin
               state_in = ST_START;
               if (detect_enable) action_in = ACT_RELEASE;
            end
         end
         ST_M112: begin
            if (c == CHAR_LF) begin
               state_in = ST_START;
               if (detect_enable) begin
                  action_in = ACT_KILL;
                  killed_in = 1'b1;
               end
            end
         end
         ST_M410: begin
            if (c == CHAR_LF) begin
               state_in = ST_START;
               if (detect_enable) action_in = ACT_QSTOP;
            end
         end
         default: begin
            state_in = (c == CHAR_LF) ? ST_START : ST_SKIP;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) valid_in = 1'b1;
      else if (rsp.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_START;
         killed_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            state_ff  <= state_in;
            killed_ff <= killed_in;
         end
      end
      if (fire) action_ff <= action_in;
   end

   assign rsp.valid  = valid_ff;
   assign rsp.action = action_ff;
   assign rsp.killed = killed_ff;

endmodule

[design/emergency_command_sniffer.sv]
// ----------------------------------------------------------------------------
// emergency_command_sniffer
// watches a serial text stream for the urgent commands M108, M112 and M410
// ----------------------------------------------------------------------------
// One byte per transaction enters on req; every byte gives exactly one result
// on rsp with the action code (nonzero only for the newline that ends a
// matched command while detection is enabled) and the sticky killed flag.
// A byte passes an input register and then the parser, whose next state is a
// small function of state and byte, so one byte is taken every cycle while rsp
// is ready; its result is held in the parser's result register for rsp. While
// a result waits on rsp the input register can take one more byte, then req
// stalls. csr_we writes csr_wdata into the detect enable bit, reset to 1.
module emergency_command_sniffer import esn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   esn_req_if.sink   req,
   esn_rsp_if.source rsp,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   logic      detect_enable_ff;
   logic      detect_enable_in;
   logic      take;
   stage_type stage;

   assign detect_enable_in = csr_we ? csr_wdata : detect_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_enable_ff <= 1'b1;
      end else begin
         detect_enable_ff <= detect_enable_in;
      end
   end

   esn_in_reg u_in_reg (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .take  (take),
      .stage (stage)
   );

   esn_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .detect_enable (detect_enable_ff),
      .take          (take),
      .rsp           (rsp)
   );

endmodule
